// File: rtl/radial_tracking_acceleration_top_assert.svh
// assertion macros for the radial tracking acceleration block
// expects signals named clock and reset in the including module
`ifndef RADIAL_TRACKING_ACCELERATION_TOP_ASSERT_SVH
`define RADIAL_TRACKING_ACCELERATION_TOP_ASSERT_SVH

// same-cycle implication
`define RTA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rta assertion failed");

// next-cycle implication
`define RTA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rta assertion failed");

`endif

// File: rtl/rta_pkg.sv
// shared constants and widths for the radial tracking acceleration block
// no dependencies
package rta_pkg;

   localparam int FRAC_BITS  = 4;
   localparam int DIM_W      = 12;
   localparam int POS_W      = 16;
   localparam int ACC_W      = 16;
   localparam int MARGIN_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_LOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_HIGH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_MARGIN  = 3'd4;

   localparam logic [DIM_W-1:0]    WIDTH_RST  = 12'd640;
   localparam logic [DIM_W-1:0]    HEIGHT_RST = 12'd480;
   localparam logic [ACC_W-1:0]    LOW_RST    = 16'd0;
   localparam logic [ACC_W-1:0]    HIGH_RST   = 16'hFFFF;
   localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd0;

   // doubled lengths in units of 2^-FRAC_BITS pixel
   localparam int CTR_W     = DIM_W + FRAC_BITS;
   localparam int TWO_POS_W = POS_W + 1;
   localparam int DX_W      = ((TWO_POS_W > CTR_W) ? TWO_POS_W : CTR_W) + 1;
   localparam int R2_W      = ((MARGIN_W + 1 > CTR_W) ? MARGIN_W + 1 : CTR_W) + 1;
   localparam int R_W       = CTR_W;
   localparam int SQ_W      = 2 * DX_W - 1;
   localparam int SUM_W     = SQ_W + 1;
   localparam int RAD_W     = SUM_W + (SUM_W % 2);

   // fraction in Q1.16 so that one is representable; quotient bits in Q0.16
   localparam int Q_FRAC    = 16;
   localparam int QUO_W     = Q_FRAC;
   localparam int F_W       = Q_FRAC + 1;
   localparam int ROOT_W    = RAD_W / 2 + Q_FRAC;
   localparam int REM_W     = ROOT_W + 3;

   localparam int DIFF_W    = ACC_W + 1;
   localparam int PROD_W    = F_W + 1 + DIFF_W;

   // diff, square, sum, root steps, prep, divide steps, multiply
   localparam int NST       = ROOT_W + QUO_W + 5;
   localparam int SQRT_BASE = 2;
   localparam int DIV_BASE  = SQRT_BASE + ROOT_W + 1;

   localparam logic [F_W-1:0] F_ONE = F_W'(1) << Q_FRAC;

endpackage

// File: rtl/rta_req_if.sv
// request channel: tracked position with valid/ready handshake
// depends on rta_pkg
interface rta_req_if;
   logic                      valid;
   logic                      ready;
   logic [rta_pkg::POS_W-1:0] target_col;
   logic [rta_pkg::POS_W-1:0] target_row;

   modport source (output valid, output target_col, output target_row, input ready);
   modport sink (input valid, input target_col, input target_row, output ready);
endinterface

// File: rtl/rta_rsp_if.sv
// response channel: acceleration value with valid/ready handshake
// depends on rta_pkg
interface rta_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rta_pkg::ACC_W-1:0] accel_value;

   modport source (output valid, output accel_value, input ready);
   modport sink (input valid, input accel_value, output ready);
endinterface

// File: rtl/radial_tracking_acceleration_top.sv
// accepts one request per cycle unless the pipe is stalled by a full output buffer
// pipeline: offsets, squares, sum, one restoring square root step per stage (34),
// prep, one divide step per stage (16), multiply, then a two-entry output buffer
// the whole pipe stalls only when both output entries hold a waiting response
// reset is synchronous: clears valid bits and loads the default register values
// depends on rta_pkg, rta_req_if, rta_rsp_if, radial_tracking_acceleration_top_assert.svh
`include "radial_tracking_acceleration_top_assert.svh"

module radial_tracking_acceleration_top (
   input  logic                           clock,
   input  logic                           reset,
   rta_req_if.sink                        req_if,
   rta_rsp_if.source                      rsp_if,
   input  logic                           csr_write_en,
   input  logic [rta_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rta_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int DX_W   = rta_pkg::DX_W;
   localparam int SQ_W   = rta_pkg::SQ_W;
   localparam int RAD_W  = rta_pkg::RAD_W;
   localparam int ROOT_W = rta_pkg::ROOT_W;
   localparam int REM_W  = rta_pkg::REM_W;
   localparam int R_W    = rta_pkg::R_W;
   localparam int R2_W   = rta_pkg::R2_W;
   localparam int QUO_W  = rta_pkg::QUO_W;
   localparam int F_W    = rta_pkg::F_W;
   localparam int DIFF_W = rta_pkg::DIFF_W;
   localparam int PROD_W = rta_pkg::PROD_W;
   localparam int ACC_W  = rta_pkg::ACC_W;
   localparam int NST    = rta_pkg::NST;

   // configuration registers
   logic [rta_pkg::DIM_W-1:0]    image_width_ff, image_height_ff;
   logic [ACC_W-1:0]             accel_low_ff, accel_high_ff;
   logic [rta_pkg::MARGIN_W-1:0] edge_margin_ff;

   // values derived from configuration
   logic [R2_W-1:0]          r2;
   logic [rta_pkg::DIM_W-1:0] side;
   logic [R_W-1:0]           r_ff;
   logic                     r_pos_ff;
   logic signed [DIFF_W-1:0] diff_ff;

   // pipeline control
   logic           en;
   logic [NST-1:0] pipe_v_ff, pipe_v_in;

   // offset and square stages
   logic [DX_W-1:0]         ctr_x, ctr_y;
   logic signed [DX_W-1:0]  dx_ff, dy_ff;
   logic signed [2*DX_W-1:0] prod_x, prod_y;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff;

   // square root stages
   logic [RAD_W-1:0]  rad_ff [0:ROOT_W-1];
   logic [RAD_W-1:0]  rad_in [0:ROOT_W-1];
   logic [REM_W-1:0]  rem_ff [0:ROOT_W];
   logic [REM_W-1:0]  rem_in [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W];
   logic [ROOT_W-1:0] root_in [0:ROOT_W];

   // divide stages
   logic [R_W-1:0]   drem_ff [0:QUO_W];
   logic [R_W-1:0]   drem_in [0:QUO_W];
   logic [QUO_W-1:0] dquo_ff [0:QUO_W];
   logic [QUO_W-1:0] dquo_in [0:QUO_W];
   logic             sat_ff [0:QUO_W];
   logic             sat_in [0:QUO_W];

   // interpolation
   logic [F_W-1:0]           frac;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] q_shift;
   logic [ACC_W-1:0]         accel_calc;

   // output buffer
   logic             out_v_ff, skid_v_ff;
   logic [ACC_W-1:0] out_ff, skid_ff;
   logic             push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= rta_pkg::WIDTH_RST;
         image_height_ff <= rta_pkg::HEIGHT_RST;
         accel_low_ff    <= rta_pkg::LOW_RST;
         accel_high_ff   <= rta_pkg::HIGH_RST;
         edge_margin_ff  <= rta_pkg::MARGIN_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            rta_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[rta_pkg::DIM_W-1:0];
            rta_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data[rta_pkg::DIM_W-1:0];
            rta_pkg::CSR_ACCEL_LOW:    accel_low_ff    <= csr_write_data[ACC_W-1:0];
            rta_pkg::CSR_ACCEL_HIGH:   accel_high_ff   <= csr_write_data[ACC_W-1:0];
            rta_pkg::CSR_EDGE_MARGIN:
               edge_margin_ff <= csr_write_data[rta_pkg::MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // usable radius, doubled
   assign side = (image_width_ff < image_height_ff) ? image_width_ff : image_height_ff;
   assign r2   = (R2_W'(side) << rta_pkg::FRAC_BITS) - R2_W'({edge_margin_ff, 1'b0});

   always_ff @(posedge clock) begin
      r_ff     <= r2[R_W-1:0];
      r_pos_ff <= !r2[R2_W-1] && (r2 != '0);
      diff_ff  <= $signed(DIFF_W'(accel_high_ff)) - $signed(DIFF_W'(accel_low_ff));
   end

   assign en            = !skid_v_ff;
   assign req_if.ready  = en;
   assign pipe_v_in     = {pipe_v_ff[NST-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= '0;
      end else if (en) begin
         pipe_v_ff <= pipe_v_in;
      end
   end

   // offsets from the doubled centre
   assign ctr_x  = DX_W'(image_width_ff) << rta_pkg::FRAC_BITS;
   assign ctr_y  = DX_W'(image_height_ff) << rta_pkg::FRAC_BITS;
   assign prod_x = (2*DX_W)'(dx_ff) * (2*DX_W)'(dx_ff);
   assign prod_y = (2*DX_W)'(dy_ff) * (2*DX_W)'(dy_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= DX_W'({req_if.target_col, 1'b0}) - ctr_x;
         dy_ff  <= DX_W'({req_if.target_row, 1'b0}) - ctr_y;
         sqx_ff <= prod_x[SQ_W-1:0];
         sqy_ff <= prod_y[SQ_W-1:0];
      end
   end

   // restoring square root of sum << 32, two radicand bits per stage
   always_comb begin
      logic [REM_W-1:0] t;
      logic [REM_W-1:0] trial;
      rad_in[0]  = RAD_W'(sqx_ff) + RAD_W'(sqy_ff);
      rem_in[0]  = '0;
      root_in[0] = '0;
      for (int k = 0; k < ROOT_W; k++) begin
         t     = {rem_ff[k][REM_W-3:0], rad_ff[k][RAD_W-1 -: 2]};
         trial = REM_W'({root_ff[k], 2'b01});
         if (t >= trial) begin
            rem_in[k+1]  = t - trial;
            root_in[k+1] = {root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k+1]  = t;
            root_in[k+1] = {root_ff[k][ROOT_W-2:0], 1'b0};
         end
         if (k < ROOT_W - 1) begin
            rad_in[k+1] = rad_ff[k] << 2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   // fraction = root / r, saturating at one, and forced to one when r is not positive
   always_comb begin
      logic [R_W:0] t;
      sat_in[0]  = !r_pos_ff ||
                   (root_ff[ROOT_W] >= ROOT_W'({r_ff, QUO_W'(0)}));
      drem_in[0] = root_ff[ROOT_W][QUO_W +: R_W];
      dquo_in[0] = root_ff[ROOT_W][QUO_W-1:0];
      for (int j = 0; j < QUO_W; j++) begin
         t = {drem_ff[j], dquo_ff[j][QUO_W-1]};
         sat_in[j+1] = sat_ff[j];
         if (t >= {1'b0, r_ff}) begin
            drem_in[j+1] = R_W'(t - {1'b0, r_ff});
            dquo_in[j+1] = {dquo_ff[j][QUO_W-2:0], 1'b1};
         end else begin
            drem_in[j+1] = t[R_W-1:0];
            dquo_in[j+1] = {dquo_ff[j][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         drem_ff <= drem_in;
         dquo_ff <= dquo_in;
         sat_ff  <= sat_in;
      end
   end

   // interpolation with floored product
   assign frac = sat_ff[QUO_W] ? rta_pkg::F_ONE : {1'b0, dquo_ff[QUO_W]};

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PROD_W'($signed({1'b0, frac})) * PROD_W'(diff_ff);
      end
   end

   assign q_shift    = prod_ff >>> rta_pkg::Q_FRAC;
   assign accel_calc = q_shift[ACC_W-1:0] + accel_low_ff;

   // two-entry output buffer
   assign push = en && pipe_v_ff[NST-1];
   assign pop  = out_v_ff && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         priority if (skid_v_ff) begin
            if (pop) begin
               skid_v_ff <= 1'b0;
            end
         end else if (out_v_ff && !pop && push) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= push || (out_v_ff && !pop);
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (skid_v_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (out_v_ff && !pop && push) begin
         skid_ff <= accel_calc;
      end else if (push) begin
         out_ff <= accel_calc;
      end else begin
         out_ff <= out_ff;
      end
   end

   assign rsp_if.valid       = out_v_ff;
   assign rsp_if.accel_value = out_ff;

   `RTA_ASSERT_IMPL(a_skid_behind_out, skid_v_ff, out_v_ff)
   `RTA_ASSERT_NEXT(a_tail_held_on_full, pipe_v_ff[NST-1] && skid_v_ff, pipe_v_ff[NST-1])
   `RTA_ASSERT_IMPL(a_root_rem_bound, pipe_v_ff[rta_pkg::SQRT_BASE + ROOT_W],
      rem_ff[ROOT_W] <= REM_W'({root_ff[ROOT_W], 1'b0}))
   `RTA_ASSERT_IMPL(a_div_rem_bound, pipe_v_ff[rta_pkg::DIV_BASE + QUO_W] && !sat_ff[QUO_W],
      drem_ff[QUO_W] < r_ff)
   `RTA_ASSERT_NEXT(a_accept_enters, req_if.valid && req_if.ready, pipe_v_ff[0])

endmodule
